// ===== rtl/core/nlfsr48_pkg.sv =====
package nlfsr48_pkg;

  // Operation codes carried by the opcode field of an input transaction.
  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_AUTH   = 2'd1,
    OP_XCRYPT = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Filter tables: two 4-input functions and the 5-input combining function.
  localparam logic [15:0] TAB_A = 16'h2C79;
  localparam logic [15:0] TAB_B = 16'h6671;
  localparam logic [31:0] TAB_C = 32'h7907287B;

  // Widths of the cipher state and of the round counter.
  localparam int unsigned STATE_W  = 48;
  localparam int unsigned ROUND_W  = 6;
  localparam logic [ROUND_W-1:0] INIT_ROUNDS = 6'd32;
  localparam logic [ROUND_W-1:0] AUTH_ROUNDS = 6'd32;
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // APB register map: one 64-bit register every eight bytes.
  localparam int unsigned ADDR_W = 4;
  localparam logic [0:0] REG_KEY    = 1'b0;
  localparam logic [0:0] REG_SERIAL = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the fields of an accepted transaction
    logic step;     // run one cipher round
    logic publish;  // write the result into the output register
    op_t  op;       // operation the command belongs to
  } cmd_t;

  // Twenty-input nonlinear output filter.
  function automatic logic filter20(input logic [STATE_W-1:0] v);
    logic [4:0] sel;
    sel[0] = TAB_A[{v[5], v[4], v[2], v[1]}];
    sel[1] = TAB_B[{v[14], v[13], v[11], v[7]}];
    sel[2] = TAB_B[{v[25], v[22], v[20], v[16]}];
    sel[3] = TAB_B[{v[32], v[30], v[28], v[27]}];
    sel[4] = TAB_A[{v[45], v[43], v[42], v[33]}];
    return TAB_C[sel];
  endfunction

  // Linear feedback taps of the shift register.
  function automatic logic lfsr_fb(input logic [STATE_W-1:0] v);
    return v[0] ^ v[2] ^ v[3] ^ v[6] ^ v[7] ^ v[8] ^ v[16] ^ v[22] ^ v[23]
         ^ v[26] ^ v[30] ^ v[41] ^ v[42] ^ v[43] ^ v[46] ^ v[47];
  endfunction

endpackage

// ===== rtl/core/nlfsr48_if.sv =====
// Input channel: one cipher operation per transaction.
interface nlfsr48_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] init_vector;
  logic [31:0] auth_word;
  logic [7:0]  data_byte;
  logic [3:0]  bit_count;

  modport source (
    output valid, opcode, init_vector, auth_word, data_byte, bit_count,
    input  ready
  );
  modport sink (
    input  valid, opcode, init_vector, auth_word, data_byte, bit_count,
    output ready
  );
endinterface

// Output channel: one result per operation.
interface nlfsr48_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       auth_ok;

  modport source (
    output valid, data_out, auth_ok,
    input  ready
  );
  modport sink (
    input  valid, data_out, auth_ok,
    output ready
  );
endinterface

// ===== rtl/core/nlfsr_48bit_stream_cipher.sv =====
// Each operation runs n rounds (32 for init and authenticate, the bit count saturated
// at eight for transcrypt, none for opcode three): the transaction is loaded, the rounds
// run, and the result is published into the output register once that is free.
// Throughput: one operation at a time, one cipher round per clock; the next
// transaction is accepted only after the result has been published.
// Reset (synchronous, active high) clears the key, serial and cipher state to
// zero and empties the output register.
module nlfsr_48bit_stream_cipher (
  input  logic                           clk,
  input  logic                           rst,
  nlfsr48_in_if.sink                     in_chan,
  nlfsr48_out_if.source                  out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nlfsr48_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                    pwdata,
  output logic [63:0]                    prdata,
  output logic                           pready
);

  logic [nlfsr48_pkg::STATE_W-1:0] secret_key;
  logic [31:0]                     tag_serial;
  nlfsr48_pkg::cmd_t               cmd;
  logic                            in_ready;
  logic                            out_valid;

  // Configuration registers.
  nlfsr48_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .secret_key (secret_key),
    .tag_serial (tag_serial)
  );

  // Sequencer.
  nlfsr48_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .opcode    (in_chan.opcode),
    .bit_count (in_chan.bit_count),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  // Cipher datapath and result register.
  nlfsr48_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .init_vector (in_chan.init_vector),
    .auth_word   (in_chan.auth_word),
    .data_byte   (in_chan.data_byte),
    .secret_key  (secret_key),
    .tag_serial  (tag_serial),
    .data_out    (out_chan.data_out),
    .auth_ok     (out_chan.auth_ok)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

endmodule

// ===== rtl/core/nlfsr48_regs.sv =====
module nlfsr48_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [nlfsr48_pkg::ADDR_W-1:0]   paddr,
  input  logic [63:0]                      pwdata,
  output logic [63:0]                      prdata,
  output logic                             pready,
  output logic [nlfsr48_pkg::STATE_W-1:0]  secret_key,
  output logic [31:0]                      tag_serial
);

  logic       wr_en;
  logic [0:0] reg_sel;

  // The register index is bit 3 of the byte address; lower bits are ignored.
  assign reg_sel = paddr[3:3];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      secret_key <= '0;
      tag_serial <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        nlfsr48_pkg::REG_KEY:    secret_key <= pwdata[nlfsr48_pkg::STATE_W-1:0];
        nlfsr48_pkg::REG_SERIAL: tag_serial <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    case (reg_sel)
      nlfsr48_pkg::REG_KEY:    prdata = {16'd0, secret_key};
      nlfsr48_pkg::REG_SERIAL: prdata = {32'd0, tag_serial};
      default:                 prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/nlfsr48_ctrl.sv =====
module nlfsr48_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              opcode,
  input  logic [3:0]              bit_count,
  output logic                    out_valid,
  input  logic                    out_ready,
  output nlfsr48_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t                              state;
  state_t                              state_next;
  nlfsr48_pkg::op_t                    op;
  nlfsr48_pkg::op_t                    in_op;
  logic [nlfsr48_pkg::ROUND_W-1:0]     rounds_left;
  logic [nlfsr48_pkg::ROUND_W-1:0]     rounds_req;
  logic [3:0]                          bits_sat;
  logic                                accept;
  logic                                slot_free;

  assign in_op     = nlfsr48_pkg::op_t'(opcode);
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // Number of rounds an operation needs; the bit count saturates at a byte.
  always_comb begin
    bits_sat = (bit_count > nlfsr48_pkg::BYTE_BITS) ? nlfsr48_pkg::BYTE_BITS : bit_count;
    case (in_op)
      nlfsr48_pkg::OP_INIT:   rounds_req = nlfsr48_pkg::INIT_ROUNDS;
      nlfsr48_pkg::OP_AUTH:   rounds_req = nlfsr48_pkg::AUTH_ROUNDS;
      nlfsr48_pkg::OP_XCRYPT: rounds_req = {2'd0, bits_sat};
      default:                rounds_req = '0;
    endcase
  end

  // Next state and datapath commands.
  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.step    = 1'b0;
    cmd.publish = 1'b0;
    cmd.op      = op;
    case (state)
      S_IDLE: begin
        cmd.op = in_op;
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = (rounds_req == '0) ? S_HOLD : S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (rounds_left == nlfsr48_pkg::ROUND_W'(1)) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State, round counter and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op          <= nlfsr48_pkg::OP_NONE;
      rounds_left <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        op          <= in_op;
        rounds_left <= rounds_req;
      end else if (cmd.step) begin
        rounds_left <= rounds_left - 1'b1;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A result is only written into a free output register.
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("result published over a pending transaction");

  // The counter never runs out while rounds are still being issued.
  a_run_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (rounds_left != '0))
    else $error("round issued with an empty counter");

  // A published result is offered in the following cycle.
  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> out_valid)
    else $error("published result not offered");

  // No new transaction is taken while rounds are in flight.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !cmd.load)
    else $error("load during a running operation");

endmodule

// ===== rtl/core/nlfsr48_dp.sv =====
module nlfsr48_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  nlfsr48_pkg::cmd_t                cmd,
  input  logic [31:0]                      init_vector,
  input  logic [31:0]                      auth_word,
  input  logic [7:0]                       data_byte,
  input  logic [nlfsr48_pkg::STATE_W-1:0]  secret_key,
  input  logic [31:0]                      tag_serial,
  output logic [7:0]                       data_out,
  output logic                             auth_ok
);

  logic [nlfsr48_pkg::STATE_W-1:0] cipher_state;
  logic [nlfsr48_pkg::STATE_W-1:0] ks_state_next;
  logic [nlfsr48_pkg::STATE_W-1:0] init_shift;
  logic                            ks_bit;
  logic                            init_bit;
  logic [31:0]                     iv_sh;
  logic [31:0]                     key_sh;
  logic [31:0]                     ks_acc;
  logic [31:0]                     auth_ref;
  logic [7:0]                      data_reg;
  logic [2:0]                      bit_ptr;

  // One round: normal rounds feed back linearly and filter the new state;
  // init rounds feed back the filter output mixed with IV and key bits.
  always_comb begin
    ks_state_next = {nlfsr48_pkg::lfsr_fb(cipher_state), cipher_state[47:1]};
    ks_bit        = nlfsr48_pkg::filter20(ks_state_next);
    init_shift    = {1'b0, cipher_state[47:1]};
    init_bit      = nlfsr48_pkg::filter20(init_shift) ^ iv_sh[0] ^ key_sh[0];
  end

  // Cipher state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_state <= '0;
    end else if (cmd.load && (cmd.op == nlfsr48_pkg::OP_INIT)) begin
      cipher_state <= {secret_key[15:0], tag_serial};
    end else if (cmd.step) begin
      case (cmd.op)
        nlfsr48_pkg::OP_INIT:   cipher_state <= {init_bit, cipher_state[47:1]};
        nlfsr48_pkg::OP_AUTH:   cipher_state <= ks_state_next;
        nlfsr48_pkg::OP_XCRYPT: cipher_state <= ks_state_next;
        default:                cipher_state <= cipher_state;
      endcase
    end
  end

  // Operand capture, keystream collection and result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      iv_sh    <= init_vector;
      key_sh   <= secret_key[47:16];
      auth_ref <= auth_word;
      data_reg <= data_byte;
      bit_ptr  <= 3'd7;
    end else if (cmd.step) begin
      case (cmd.op)
        nlfsr48_pkg::OP_INIT: begin
          iv_sh  <= {1'b0, iv_sh[31:1]};
          key_sh <= {1'b0, key_sh[31:1]};
        end
        nlfsr48_pkg::OP_AUTH: begin
          ks_acc <= {ks_acc[30:0], ks_bit};
        end
        nlfsr48_pkg::OP_XCRYPT: begin
          data_reg[bit_ptr] <= data_reg[bit_ptr] ^ ks_bit;
          bit_ptr           <= bit_ptr - 1'b1;
        end
        default: ;
      endcase
    end
    if (cmd.publish) begin
      data_out <= (cmd.op == nlfsr48_pkg::OP_XCRYPT) ? data_reg : 8'd0;
      auth_ok  <= (cmd.op == nlfsr48_pkg::OP_AUTH) && ((~ks_acc) == auth_ref);
    end
  end

endmodule

// ===== verif/tb_nlfsr_48bit_stream_cipher.sv =====
module tb_nlfsr_48bit_stream_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  // Linear feedback taps of the 48-bit register: bits 0,2,3,6,7,8,16,22,23,26,30,41,42,43,46,47.
  localparam logic [47:0] FB_TAPS = 48'hCE00_44C1_01CD;

  // One cipher operation as carried by an input transaction.
  typedef struct {
    nlfsr48_pkg::op_t op;
    logic [31:0]      iv;
    logic [31:0]      aw;
    logic [7:0]       db;
    logic [3:0]       bc;
  } op_item_t;

  // One result as carried by an output transaction.
  typedef struct {
    logic [7:0] data_out;
    logic       auth_ok;
  } result_t;

  // Cipher predictor with its own key, serial and register, plus the queue of
  // results still owed by the block.
  class cipher_scoreboard;
    logic [47:0] key;
    logic [31:0] serial;
    logic [47:0] lfsr;
    result_t     owed[$];
    int          errors;

    function new();
      key    = '0;
      serial = '0;
      lfsr   = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [63:0] val);
      if (idx == nlfsr48_pkg::REG_KEY) begin
        key = val[47:0];
      end else begin
        serial = val[31:0];
      end
    endfunction

    function logic [3:0] tap4(logic [47:0] v, int a, int b, int c, int d);
      return {v[d], v[c], v[b], v[a]};
    endfunction

    // Two outer 4-input tables, three inner ones, combined by the 5-input table.
    function logic filter_out(logic [47:0] v);
      logic [4:0] sel;
      sel[0] = nlfsr48_pkg::TAB_A[tap4(v, 1, 2, 4, 5)];
      sel[1] = nlfsr48_pkg::TAB_B[tap4(v, 7, 11, 13, 14)];
      sel[2] = nlfsr48_pkg::TAB_B[tap4(v, 16, 20, 22, 25)];
      sel[3] = nlfsr48_pkg::TAB_B[tap4(v, 27, 28, 30, 32)];
      sel[4] = nlfsr48_pkg::TAB_A[tap4(v, 33, 42, 43, 45)];
      return nlfsr48_pkg::TAB_C[sel];
    endfunction

    // Shift right once with linear feedback into the top bit, then filter.
    function logic clock_round(inout logic [47:0] v);
      v = {^(v & FB_TAPS), v[47:1]};
      return filter_out(v);
    endfunction

    // The authenticator the block would accept next, worked out on a copy.
    function logic [31:0] auth_word_for();
      logic [47:0] v;
      logic [31:0] ks;
      v = lfsr;
      ks = '0;
      for (int i = 0; i < 32; i++) begin
        ks = {ks[30:0], clock_round(v)};
      end
      return ~ks;
    endfunction

    function void note_input(op_item_t it);
      result_t     exp_res;
      logic [47:0] v;
      logic [31:0] ks;
      int          cnt;
      exp_res.data_out = '0;
      exp_res.auth_ok  = 1'b0;
      case (it.op)
        nlfsr48_pkg::OP_INIT: begin
          // Low key half above the serial, then IV and upper key mixed in.
          v = {key[15:0], serial};
          for (int i = 0; i < 32; i++) begin
            v = v >> 1;
            v[47] = filter_out(v) ^ it.iv[i] ^ key[i+16];
          end
          lfsr = v;
        end
        nlfsr48_pkg::OP_AUTH: begin
          ks = '0;
          for (int i = 0; i < 32; i++) begin
            ks = {ks[30:0], clock_round(lfsr)};
          end
          exp_res.auth_ok = (~ks == it.aw);
        end
        nlfsr48_pkg::OP_XCRYPT: begin
          // Counts above eight act as a full byte; zero leaves the byte alone.
          cnt = (it.bc > 4'd8) ? 8 : int'(it.bc);
          exp_res.data_out = it.db;
          for (int i = 0; i < cnt; i++) begin
            exp_res.data_out[7-i] = exp_res.data_out[7-i] ^ clock_round(lfsr);
          end
        end
        default: begin
        end
      endcase
      owed.push_back(exp_res);
    endfunction

    function void check_result(result_t got);
      result_t exp_res;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected result data_out=%02h auth_ok=%0d", $time,
                 got.data_out, got.auth_ok);
      end else begin
        exp_res = owed.pop_front();
        if (got.data_out !== exp_res.data_out) begin
          errors++;
          $display("%0t: data_out mismatch: expected %02h, actual %02h", $time,
                   exp_res.data_out, got.data_out);
        end
        if (got.auth_ok !== exp_res.auth_ok) begin
          errors++;
          $display("%0t: auth_ok mismatch: expected %0d, actual %0d", $time,
                   exp_res.auth_ok, got.auth_ok);
        end
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [nlfsr48_pkg::ADDR_W-1:0]  paddr;
  logic [63:0]                     pwdata;
  logic [63:0]                     prdata;
  logic                            pready;
  bit                              src_quiet;
  bit                              snk_quiet;
  cipher_scoreboard                sb = new();

  nlfsr48_in_if  in_bus();
  nlfsr48_out_if out_bus();

  nlfsr_48bit_stream_cipher DUT (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Wait length for one transaction; now and then switch to a stretch with no idling.
  function automatic int pick_wait(inout bit quiet);
    if ($urandom_range(0, 31) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic op_item_t mk(nlfsr48_pkg::op_t op, logic [31:0] iv, logic [31:0] aw,
                                  logic [7:0] db, logic [3:0] bc);
    op_item_t it;
    it.op = op;
    it.iv = iv;
    it.aw = aw;
    it.db = db;
    it.bc = bc;
    return it;
  endfunction

  // Random fields; the bit count is mostly a full byte.
  function automatic op_item_t rand_item(nlfsr48_pkg::op_t op);
    logic [3:0] bc;
    bc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
    return mk(op, $urandom, $urandom, 8'($urandom_range(0, 255)), bc);
  endfunction

  // Offer one input transaction and note it once accepted.
  task automatic send(input op_item_t it);
    int gap;
    gap = pick_wait(src_quiet);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.opcode      <= it.op;
    in_bus.init_vector <= it.iv;
    in_bus.auth_word   <= it.aw;
    in_bus.data_byte   <= it.db;
    in_bus.bit_count   <= it.bc;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    sb.note_input(it);
  endtask

  // Authenticate, with the word that matches the keystream when asked.
  task automatic send_auth(bit match);
    op_item_t it;
    it = rand_item(nlfsr48_pkg::OP_AUTH);
    if (match) it.aw = sb.auth_word_for();
    send(it);
  endtask

  // Stop offering and let every owed result come back.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(logic [0:0] idx, logic [63:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_keys(logic [47:0] k, logic [31:0] s);
    drain();
    apb_write(nlfsr48_pkg::REG_KEY, {16'h0, k});
    apb_write(nlfsr48_pkg::REG_SERIAL, {32'h0, s});
  endtask

  // Mostly whole sessions (init, authenticate, a run of bytes), some noise.
  task automatic run_phase(int target);
    int sent;
    int n;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 9) < 8) begin
        send(rand_item(nlfsr48_pkg::OP_INIT));
        send_auth($urandom_range(0, 3) != 0);
        n = $urandom_range(1, 12);
        repeat (n) send(rand_item(nlfsr48_pkg::OP_XCRYPT));
        sent += n + 2;
      end else begin
        n = $urandom_range(0, 3);
        if (nlfsr48_pkg::op_t'(n) == nlfsr48_pkg::OP_AUTH) begin
          send_auth($urandom_range(0, 1));
        end else begin
          send(rand_item(nlfsr48_pkg::op_t'(n)));
        end
        sent++;
      end
    end
  endtask

  // Result side: random stalls, each result checked as it is taken.
  initial begin
    int      stall;
    result_t got;
    out_bus.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = pick_wait(snk_quiet);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      got.data_out = out_bus.data_out;
      got.auth_ok  = out_bus.auth_ok;
      sb.check_result(got);
    end
  end

  // Main sequence.
  initial begin
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.opcode      <= nlfsr48_pkg::OP_INIT;
    in_bus.init_vector <= '0;
    in_bus.auth_word   <= '0;
    in_bus.data_byte   <= '0;
    in_bus.bit_count   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Before any init the register is all zero, so the keystream is too.
    send(mk(nlfsr48_pkg::OP_AUTH, 32'h0, 32'hFFFF_FFFF, 8'h00, 4'd8));
    send(mk(nlfsr48_pkg::OP_XCRYPT, 32'h0, 32'h0, 8'hFF, 4'd8));

    // All-ones key and serial; bit count edges including saturation and zero.
    set_keys(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send(mk(nlfsr48_pkg::OP_INIT, 32'h0, 32'h0, 8'h00, 4'd0));
    send_auth(1'b1);
    send(mk(nlfsr48_pkg::OP_XCRYPT, 32'h0, 32'h0, 8'h00, 4'd0));
    send(mk(nlfsr48_pkg::OP_XCRYPT, 32'h0, 32'h0, 8'hFF, 4'd8));
    send(mk(nlfsr48_pkg::OP_XCRYPT, 32'h0, 32'h0, 8'hA5, 4'd15));
    send(mk(nlfsr48_pkg::OP_XCRYPT, 32'h0, 32'h0, 8'h5A, 4'd9));
    send(mk(nlfsr48_pkg::OP_XCRYPT, 32'h0, 32'h0, 8'h00, 4'd1));
    send(mk(nlfsr48_pkg::OP_XCRYPT, 32'h0, 32'h0, 8'hFF, 4'd7));
    send(mk(nlfsr48_pkg::OP_INIT, 32'hFFFF_FFFF, 32'h0, 8'h00, 4'd0));
    send(mk(nlfsr48_pkg::OP_AUTH, 32'h0, 32'h0, 8'h00, 4'd0));
    send(mk(nlfsr48_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'hF));
    send(mk(nlfsr48_pkg::OP_NONE, 32'h0, 32'h0, 8'h00, 4'h0));
    send(mk(nlfsr48_pkg::OP_XCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 4'd8));

    // Back to an all-zero key and serial.
    set_keys(48'h0, 32'h0);
    send(mk(nlfsr48_pkg::OP_INIT, 32'hA5A5_A5A5, 32'h0, 8'h00, 4'd8));
    send_auth(1'b1);
    send(mk(nlfsr48_pkg::OP_XCRYPT, 32'h0, 32'h0, 8'h3C, 4'd8));

    // Random phases, each under its own key and serial.
    set_keys(48'hFFFF_FFFF_FFFF, 32'h0);
    run_phase(210);
    set_keys(48'h0, 32'hFFFF_FFFF);
    run_phase(210);
    repeat (3) begin
      set_keys(48'({$urandom, $urandom}), $urandom);
      run_phase(210);
    end

    // Let the last results come back, then let the bench idle.
    in_bus.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
